// ----- sv/pffa_pkg.sv -----
// Package for the potential-field force accumulator.
// Holds register indexes, fixed widths, reset values and the sequencer state type.
// No dependencies.
package pffa_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int FORCE_W         = 32;
  localparam int ACC_W           = 48;
  localparam logic [31:0] FORCE_GAIN_RST = 32'h0001_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORCE_GAIN      = 3'd0,
    REG_OWN_CHARGE      = 3'd1,
    REG_OBSTACLE_CHARGE = 3'd2,
    REG_GOAL_CHARGE     = 3'd3,
    REG_TARGET_X        = 3'd4,
    REG_TARGET_Y        = 3'd5
  } reg_idx_t;

  typedef enum logic [12:0] {
    ST_IDLE  = 13'b0000000000001,
    ST_NEXT  = 13'b0000000000010,
    ST_GAIN1 = 13'b0000000000100,
    ST_GAIN2 = 13'b0000000001000,
    ST_SQX   = 13'b0000000010000,
    ST_SQY   = 13'b0000000100000,
    ST_SQRT  = 13'b0000001000000,
    ST_DEN   = 13'b0000010000000,
    ST_NUM   = 13'b0000100000000,
    ST_DIV   = 13'b0001000000000,
    ST_ACC   = 13'b0010000000000,
    ST_EMIT  = 13'b0100000000000,
    ST_SPARE = 13'b1000000000000
  } state_t;

endpackage

// ----- sv/potential_field_force_accumulator.sv -----
// Top level of the potential-field force accumulator.
// Uses pffa_pkg for register indexes, widths and the sequencer state type.
//
// Usage: the input channel (in_valid/in_ready) carries the drone position and at
// most one obstacle. A transfer with in_obstacle_valid adds a repulsive
// inverse-square term to two 48-bit accumulators; a transfer with in_last also
// adds the attractive term toward the configured target and then produces one
// result on the output channel (out_valid/out_ready): the force saturated to
// Q16.16, a coincidence flag and a saturation flag. Accumulators then clear.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must do so
// only while idle, and the block itself does not enforce it. One sequencer
// drives a shared multiplier, a digit-by-digit square root, a shift-add product
// and a restoring divider; the divider dominates the time of a term, and a term
// with zero distance stops once its squared distance is known.
// in_ready is high only while the sequencer is idle.
// Reset restores the registers (force_gain to 1.0, others to 0) and clears the
// accumulators. A result waits in the output register while the receiver
// stalls; the next item is still accepted and worked on, and only its own
// result waits until the earlier one is taken.
module potential_field_force_accumulator #(
  parameter int COORD_WIDTH = pffa_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [COORD_WIDTH-1:0]        in_drone_x,
  input  logic signed [COORD_WIDTH-1:0]        in_drone_y,
  input  logic signed [COORD_WIDTH-1:0]        in_obstacle_x,
  input  logic signed [COORD_WIDTH-1:0]        in_obstacle_y,
  input  logic                                 in_obstacle_valid,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pffa_pkg::FORCE_W-1:0]  out_force_x,
  output logic signed [pffa_pkg::FORCE_W-1:0]  out_force_y,
  output logic                                 out_coincident,
  output logic                                 out_saturated,
  input  logic                                 cfg_we,
  input  logic [pffa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pffa_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import pffa_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;
  localparam int SW   = 2 * DW;
  localparam int NW   = DW;
  localparam int RW   = NW + 3;
  localparam int DENW = SW + NW;
  localparam int KW   = 32;
  localparam int MW   = (DW > KW) ? DW : KW;
  localparam int PW   = 2 * MW;
  localparam int NUMW = DW + KW + 16;
  localparam int CW   = $clog2(NUMW + 1);

  localparam logic signed [ACC_W:0] ACC_MAX = {2'b00, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W:0] ACC_MIN = {2'b11, {(ACC_W-1){1'b0}}};

  function automatic logic [KW-1:0] mag32(input logic signed [KW-1:0] v);
    logic [KW-1:0] r;
    r = v[KW-1] ? KW'(-v) : KW'(v);
    return r;
  endfunction

  // Q16.16 product of two magnitudes, truncated and clipped to 32-bit signed.
  function automatic logic signed [KW-1:0] qsat(input logic [PW-1:0] prod,
                                                 input logic neg);
    logic [PW-1:0] m;
    logic signed [KW-1:0] r;
    m = prod >> 16;
    if (neg) begin
      r = (m > PW'(33'h0_8000_0000)) ? {1'b1, {(KW-1){1'b0}}} : -$signed(m[KW-1:0]);
    end else begin
      r = (m > PW'(33'h0_7FFF_FFFF)) ? {1'b0, {(KW-1){1'b1}}} : $signed(m[KW-1:0]);
    end
    return r;
  endfunction

  state_t state_r, state_nxt;

  logic signed [KW-1:0] gain_r, own_r, obsq_r, goalq_r;
  logic signed [W-1:0]  tgt_x_r, tgt_y_r;

  logic signed [W-1:0]  drx_r, dry_r, obx_r, oby_r;
  logic signed [W-1:0]  drx_nxt, dry_nxt, obx_nxt, oby_nxt;
  logic                 pend_obs_r, pend_obs_nxt, pend_last_r, pend_last_nxt;
  logic                 emit_r, emit_nxt;

  logic [DW-1:0]        mdx_r, mdx_nxt, mdy_r, mdy_nxt;
  logic                 negx_r, negx_nxt, negy_r, negy_nxt;
  logic signed [KW-1:0] charge_r, charge_nxt, p_r, p_nxt;
  logic [KW-1:0]        kmag_r, kmag_nxt;
  logic                 kneg_r, kneg_nxt, rep_r, rep_nxt, axis_r, axis_nxt;

  logic [SW-1:0]        s_r, s_nxt, sh_r, sh_nxt;
  logic [RW-1:0]        rem_r, rem_nxt;
  logic [NW-1:0]        root_r, root_nxt;
  logic [DENW-1:0]      den_r, den_nxt, dr_r, dr_nxt;
  logic [NUMW-1:0]      num_r, num_nxt, q_r, q_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;

  logic signed [ACC_W-1:0] sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  logic                    zseen_r, zseen_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [KW-1:0]    fx_r, fx_nxt, fy_r, fy_nxt;
  logic                    coin_r, coin_nxt, osat_r, osat_nxt;

  // Shared multiplier and its operand selection.
  logic [MW-1:0] mul_a, mul_b;
  logic [PW-1:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_GAIN1: begin
        mul_a = MW'(mag32(gain_r));
        mul_b = MW'(mag32(own_r));
      end
      ST_GAIN2: begin
        mul_a = MW'(mag32(p_r));
        mul_b = MW'(mag32(charge_r));
      end
      ST_SQX: begin
        mul_a = MW'(mdx_r);
        mul_b = MW'(mdx_r);
      end
      ST_SQY: begin
        mul_a = MW'(mdy_r);
        mul_b = MW'(mdy_r);
      end
      ST_NUM: begin
        mul_a = axis_r ? MW'(mdy_r) : MW'(mdx_r);
        mul_b = MW'(kmag_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Term setup: difference vector for the obstacle or the target.
  logic signed [DW-1:0] dxs, dys;
  logic                 use_obs;

  assign use_obs = pend_obs_r;
  assign dxs = use_obs ? ({obx_r[W-1], obx_r} - {drx_r[W-1], drx_r})
                       : ({tgt_x_r[W-1], tgt_x_r} - {drx_r[W-1], drx_r});
  assign dys = use_obs ? ({oby_r[W-1], oby_r} - {dry_r[W-1], dry_r})
                       : ({tgt_y_r[W-1], tgt_y_r} - {dry_r[W-1], dry_r});

  // Square-root digit step.
  logic [RW-1:0] rem_sh, trial;
  logic          sq_ge;
  assign rem_sh = {rem_r[RW-3:0], sh_r[SW-1:SW-2]};
  assign trial  = RW'({root_r, 2'b01});
  assign sq_ge  = rem_sh >= trial;

  // Restoring divider step.
  logic [DENW:0] rr;
  logic          dv_ge;
  assign rr    = {dr_r, num_r[NUMW-1]};
  assign dv_ge = rr >= {1'b0, den_r};

  // Quotient clip and signed accumulate.
  logic                    q_over, t_neg;
  logic [ACC_W-1:0]        mq;
  logic signed [ACC_W:0]   v, acc_sel, acc_sum;
  logic signed [ACC_W-1:0] acc_sat;

  assign q_over  = |q_r[NUMW-1:ACC_W-1];
  assign mq      = q_over ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, q_r[ACC_W-2:0]};
  assign t_neg   = (axis_r ? negy_r : negx_r) ^ kneg_r ^ rep_r;
  assign v       = t_neg ? -$signed({1'b0, mq})
                         : (q_over ? ACC_MAX : $signed({1'b0, mq}));
  assign acc_sel = axis_r ? {sum_y_r[ACC_W-1], sum_y_r} : {sum_x_r[ACC_W-1], sum_x_r};
  assign acc_sum = acc_sel + v;
  assign acc_sat = (acc_sum > ACC_MAX) ? ACC_MAX[ACC_W-1:0]
                 : (acc_sum < ACC_MIN) ? ACC_MIN[ACC_W-1:0]
                 : acc_sum[ACC_W-1:0];

  // Output clip to Q16.16.
  logic fx_clip, fy_clip;
  assign fx_clip = (sum_x_r[ACC_W-1:KW-1] != {(ACC_W-KW+1){sum_x_r[ACC_W-1]}});
  assign fy_clip = (sum_y_r[ACC_W-1:KW-1] != {(ACC_W-KW+1){sum_y_r[ACC_W-1]}});

  always_comb begin
    state_nxt     = state_r;
    drx_nxt       = drx_r;
    dry_nxt       = dry_r;
    obx_nxt       = obx_r;
    oby_nxt       = oby_r;
    pend_obs_nxt  = pend_obs_r;
    pend_last_nxt = pend_last_r;
    emit_nxt      = emit_r;
    mdx_nxt       = mdx_r;
    mdy_nxt       = mdy_r;
    negx_nxt      = negx_r;
    negy_nxt      = negy_r;
    charge_nxt    = charge_r;
    p_nxt         = p_r;
    kmag_nxt      = kmag_r;
    kneg_nxt      = kneg_r;
    rep_nxt       = rep_r;
    axis_nxt      = axis_r;
    s_nxt         = s_r;
    sh_nxt        = sh_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    den_nxt       = den_r;
    dr_nxt        = dr_r;
    num_nxt       = num_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    sum_x_nxt     = sum_x_r;
    sum_y_nxt     = sum_y_r;
    zseen_nxt     = zseen_r;
    out_valid_nxt = out_valid_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    coin_nxt      = coin_r;
    osat_nxt      = osat_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          drx_nxt       = in_drone_x;
          dry_nxt       = in_drone_y;
          obx_nxt       = in_obstacle_x;
          oby_nxt       = in_obstacle_y;
          pend_obs_nxt  = in_obstacle_valid;
          pend_last_nxt = in_last;
          state_nxt     = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (pend_obs_r || pend_last_r) begin
          mdx_nxt  = dxs[DW-1] ? DW'(-dxs) : DW'(dxs);
          mdy_nxt  = dys[DW-1] ? DW'(-dys) : DW'(dys);
          negx_nxt = dxs[DW-1];
          negy_nxt = dys[DW-1];
          rep_nxt  = use_obs;
          charge_nxt = use_obs ? obsq_r : goalq_r;
          if (use_obs) begin
            pend_obs_nxt = 1'b0;
          end else begin
            pend_last_nxt = 1'b0;
            emit_nxt      = 1'b1;
          end
          state_nxt = ST_GAIN1;
        end else if (emit_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_GAIN1: begin
        p_nxt     = qsat(prod, gain_r[KW-1] ^ own_r[KW-1]);
        state_nxt = ST_GAIN2;
      end
      ST_GAIN2: begin
        logic signed [KW-1:0] k;
        k         = qsat(prod, p_r[KW-1] ^ charge_r[KW-1]);
        kmag_nxt  = mag32(k);
        kneg_nxt  = k[KW-1];
        state_nxt = ST_SQX;
      end
      ST_SQX: begin
        s_nxt     = prod[SW-1:0];
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        s_nxt   = s_r + prod[SW-1:0];
        sh_nxt  = s_r + prod[SW-1:0];
        rem_nxt = '0;
        root_nxt = '0;
        cnt_nxt = CW'(NW);
        if (mdx_r == '0 && mdy_r == '0) begin
          zseen_nxt = 1'b1;
          state_nxt = ST_NEXT;
        end else begin
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        sh_nxt   = sh_r << 2;
        rem_nxt  = sq_ge ? (rem_sh - trial) : rem_sh;
        root_nxt = {root_r[NW-2:0], sq_ge};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          den_nxt   = '0;
          cnt_nxt   = CW'(NW);
          state_nxt = ST_DEN;
        end
      end
      ST_DEN: begin
        // Shift-add product of the squared distance and its root.
        den_nxt  = {den_r[DENW-2:0], 1'b0} + (root_r[NW-1] ? DENW'(s_r) : '0);
        root_nxt = root_r << 1;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          axis_nxt  = 1'b0;
          state_nxt = ST_NUM;
        end
      end
      ST_NUM: begin
        num_nxt   = {prod[DW+KW-1:0], 16'h0000};
        dr_nxt    = '0;
        q_nxt     = '0;
        cnt_nxt   = CW'(NUMW);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        dr_nxt  = dv_ge ? DENW'(rr - {1'b0, den_r}) : DENW'(rr);
        q_nxt   = {q_r[NUMW-2:0], dv_ge};
        num_nxt = num_r << 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (axis_r) begin
          sum_y_nxt = acc_sat;
          state_nxt = ST_NEXT;
        end else begin
          sum_x_nxt = acc_sat;
          axis_nxt  = 1'b1;
          state_nxt = ST_NUM;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          fx_nxt = fx_clip ? (sum_x_r[ACC_W-1] ? {1'b1, {(KW-1){1'b0}}}
                                               : {1'b0, {(KW-1){1'b1}}})
                           : sum_x_r[KW-1:0];
          fy_nxt = fy_clip ? (sum_y_r[ACC_W-1] ? {1'b1, {(KW-1){1'b0}}}
                                               : {1'b0, {(KW-1){1'b1}}})
                           : sum_y_r[KW-1:0];
          coin_nxt      = zseen_r;
          osat_nxt      = fx_clip | fy_clip;
          out_valid_nxt = 1'b1;
          sum_x_nxt     = '0;
          sum_y_nxt     = '0;
          zseen_nxt     = 1'b0;
          emit_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_obs_r  <= 1'b0;
      pend_last_r <= 1'b0;
      emit_r      <= 1'b0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      zseen_r     <= 1'b0;
      out_valid_r <= 1'b0;
      gain_r      <= FORCE_GAIN_RST;
      own_r       <= '0;
      obsq_r      <= '0;
      goalq_r     <= '0;
      tgt_x_r     <= '0;
      tgt_y_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_obs_r  <= pend_obs_nxt;
      pend_last_r <= pend_last_nxt;
      emit_r      <= emit_nxt;
      sum_x_r     <= sum_x_nxt;
      sum_y_r     <= sum_y_nxt;
      zseen_r     <= zseen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_FORCE_GAIN:      gain_r  <= cfg_wdata;
          REG_OWN_CHARGE:      own_r   <= cfg_wdata;
          REG_OBSTACLE_CHARGE: obsq_r  <= cfg_wdata;
          REG_GOAL_CHARGE:     goalq_r <= cfg_wdata;
          REG_TARGET_X:        tgt_x_r <= cfg_wdata[W-1:0];
          REG_TARGET_Y:        tgt_y_r <= cfg_wdata[W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    drx_r    <= drx_nxt;
    dry_r    <= dry_nxt;
    obx_r    <= obx_nxt;
    oby_r    <= oby_nxt;
    mdx_r    <= mdx_nxt;
    mdy_r    <= mdy_nxt;
    negx_r   <= negx_nxt;
    negy_r   <= negy_nxt;
    charge_r <= charge_nxt;
    p_r      <= p_nxt;
    kmag_r   <= kmag_nxt;
    kneg_r   <= kneg_nxt;
    rep_r    <= rep_nxt;
    axis_r   <= axis_nxt;
    s_r      <= s_nxt;
    sh_r     <= sh_nxt;
    rem_r    <= rem_nxt;
    root_r   <= root_nxt;
    den_r    <= den_nxt;
    dr_r     <= dr_nxt;
    num_r    <= num_nxt;
    q_r      <= q_nxt;
    cnt_r    <= cnt_nxt;
    fx_r     <= fx_nxt;
    fy_r     <= fy_nxt;
    coin_r   <= coin_nxt;
    osat_r   <= osat_nxt;
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_force_x    = fx_r;
  assign out_force_y    = fy_r;
  assign out_coincident = coin_r;
  assign out_saturated  = osat_r;

  // An accepted item keeps the sequencer busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // The divider remainder always stays below the denominator.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> dr_r < den_r)
    else $error("divider remainder out of range");

  // A new result only appears from the emit state.
  a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside emit state");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the potential-field force accumulator.
// Depends on pffa_pkg and potential_field_force_accumulator; predicts every result
// with an in-bench fixed-point model and checks each output transfer against it.
`timescale 1ns / 1ps

module testbench;
  import pffa_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_B = 3'd7;
  localparam longint ACC_HI = (longint'(1) << 47) - 1;
  localparam longint ACC_LO = -(longint'(1) << 47);
  localparam int SETTLE_CYCLES = 600;
  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic coincident;
    logic saturated;
  } force_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [CW-1:0] in_drone_x;
  logic signed [CW-1:0] in_drone_y;
  logic signed [CW-1:0] in_obstacle_x;
  logic signed [CW-1:0] in_obstacle_y;
  logic in_obstacle_valid;
  logic in_last;
  logic out_valid;
  logic out_ready;
  logic signed [FORCE_W-1:0] out_force_x;
  logic signed [FORCE_W-1:0] out_force_y;
  logic out_coincident;
  logic out_saturated;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow copy of the block's registers and accumulators.
  logic [CFG_DATA_W-1:0] shadow_regs [0:5];
  longint accum_x;
  longint accum_y;
  bit zero_dist_flag;

  force_result_t expected_forces [$];
  int send_idle_pct;
  int recv_idle_pct;
  bit failed;
  longint cycle_count = 0;

  potential_field_force_accumulator i_dut (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint unsigned abs_val(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  // Q16.16 product, truncated toward zero and clipped to 32 bits.
  function automatic longint gain_product(longint a, longint b);
    longint unsigned m;
    m = (abs_val(a) * abs_val(b)) >> 16;
    if ((a < 0) != (b < 0))
      return m > (64'd1 << 31) ? -(longint'(1) << 31) : -longint'(m);
    return m > 64'h7FFF_FFFF ? 64'sh7FFF_FFFF : longint'(m);
  endfunction

  function automatic longint acc_sat(longint acc, longint v);
    longint r;
    r = acc + v;
    if (r > ACC_HI) return ACC_HI;
    if (r < ACC_LO) return ACC_LO;
    return r;
  endfunction

  function automatic longint sreg(int idx, int w);
    logic signed [31:0] v;
    v = shadow_regs[idx];
    if (w == CW) return longint'($signed(shadow_regs[idx][CW-1:0]));
    return longint'(v);
  endfunction

  task automatic add_force_term(longint dx, longint dy, longint charge, bit repulsive);
    longint k;
    logic [127:0] sq_sum;
    logic [127:0] den;
    logic [127:0] num;
    logic [127:0] quot;
    longint unsigned root;
    longint unsigned trial;
    longint unsigned m;
    longint v;
    longint comp;
    bit neg;
    k = gain_product(gain_product(sreg(REG_FORCE_GAIN, 32), sreg(REG_OWN_CHARGE, 32)),
                     charge);
    sq_sum = 128'(abs_val(dx)) * abs_val(dx) + 128'(abs_val(dy)) * abs_val(dy);
    if (sq_sum == 0) begin
      zero_dist_flag = 1'b1;
      return;
    end
    root = 0;
    for (int b = 33; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (sq_sum >= 128'(trial) * trial) root = trial;
    end
    den = sq_sum * root;
    for (int j = 0; j < 2; j++) begin
      comp = (j == 0) ? dx : dy;
      num = (128'(abs_val(comp)) * abs_val(k)) << 16;
      quot = num / den;
      m = (quot >> 64) != 0 ? 64'hFFFF_FFFF_FFFF_FFFF : quot[63:0];
      if (m > 64'd1 << 47) m = 64'd1 << 47;
      neg = ((comp < 0) != (k < 0)) != repulsive;
      if (neg) v = -longint'(m);
      else v = (m > ACC_HI) ? ACC_HI : longint'(m);
      if (j == 0) accum_x = acc_sat(accum_x, v);
      else accum_y = acc_sat(accum_y, v);
    end
  endtask

  function automatic logic [31:0] clip_force(longint v, ref bit sat);
    if (v > 64'sh7FFF_FFFF) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -(longint'(1) << 31)) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Prediction on every accepted input transfer.
  always @(posedge clk) begin
    force_result_t r;
    bit sat;
    longint drx;
    longint dry;
    if (rst_n && in_valid && in_ready) begin
      drx = longint'(in_drone_x);
      dry = longint'(in_drone_y);
      if (in_obstacle_valid)
        add_force_term(longint'(in_obstacle_x) - drx, longint'(in_obstacle_y) - dry,
                       sreg(REG_OBSTACLE_CHARGE, 32), 1'b1);
      if (in_last) begin
        add_force_term(sreg(REG_TARGET_X, CW) - drx, sreg(REG_TARGET_Y, CW) - dry,
                       sreg(REG_GOAL_CHARGE, 32), 1'b0);
        sat = 1'b0;
        r.force_x = clip_force(accum_x, sat);
        r.force_y = clip_force(accum_y, sat);
        r.coincident = zero_dist_flag;
        r.saturated = sat;
        expected_forces = {expected_forces, r};
        accum_x = 0;
        accum_y = 0;
        zero_dist_flag = 1'b0;
      end
    end
  end

  // Result checking on every output transfer.
  always @(posedge clk) begin
    force_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_forces.size() == 0) begin
        $error("unexpected result: force_x=%0d force_y=%0d", out_force_x, out_force_y);
        failed = 1'b1;
      end else begin
        e = expected_forces.pop_front();
        if (out_force_x !== e.force_x) begin
          $error("force_x expected %0d actual %0d", e.force_x, out_force_x);
          failed = 1'b1;
        end
        if (out_force_y !== e.force_y) begin
          $error("force_y expected %0d actual %0d", e.force_y, out_force_y);
          failed = 1'b1;
        end
        if (out_coincident !== e.coincident) begin
          $error("coincident expected %0b actual %0b", e.coincident, out_coincident);
          failed = 1'b1;
        end
        if (out_saturated !== e.saturated) begin
          $error("saturated expected %0b actual %0b", e.saturated, out_saturated);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(logic signed [CW-1:0] dx, logic signed [CW-1:0] dy,
                           logic signed [CW-1:0] ox, logic signed [CW-1:0] oy,
                           logic ov, logic lst);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_drone_x <= dx;
    in_drone_y <= dy;
    in_obstacle_x <= ox;
    in_obstacle_y <= oy;
    in_obstacle_valid <= ov;
    in_last <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Lets the block drain completely before touching its registers.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_forces.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx <= REG_TARGET_Y) shadow_regs[idx] = data;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_q16();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($urandom_range(1 << 21)) - 32'(1 << 20);
      default: return 32'($urandom_range(1 << 19)) - 32'(1 << 18);
    endcase
  endfunction

  function automatic logic signed [CW-1:0] pick_coord(logic signed [CW-1:0] near);
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      2: return near;
      default: return near + CW'($urandom_range(4095)) - CW'(2048);
    endcase
  endfunction

  task automatic randomize_regs();
    logic signed [CW-1:0] tx;
    write_reg(REG_FORCE_GAIN, $urandom_range(3) == 0 ? pick_q16() : 32'h0001_0000);
    write_reg(REG_OWN_CHARGE, pick_q16());
    write_reg(REG_OBSTACLE_CHARGE, pick_q16());
    write_reg(REG_GOAL_CHARGE, pick_q16());
    tx = pick_coord('0);
    write_reg(REG_TARGET_X, 32'(tx));
    tx = pick_coord('0);
    write_reg(REG_TARGET_Y, 32'(tx));
  endtask

  task automatic test_directed();
    // Unit own and obstacle charges, goal charge 2.0, target at (1024,768) so every term is well scaled.
    write_reg(REG_OWN_CHARGE, 32'h0001_0000);
    write_reg(REG_OBSTACLE_CHARGE, 32'h0001_0000);
    write_reg(REG_GOAL_CHARGE, 32'h0002_0000);
    write_reg(REG_TARGET_X, 32'h0000_0400);
    write_reg(REG_TARGET_Y, 32'h0000_0300);
    write_reg(IDX_UNUSED_A, 32'hFFFF_FFFF);
    write_reg(IDX_UNUSED_B, 32'h1234_5678);
    send_item(0, 0, 16'sh0100, 16'sh0100, 1, 0);
    send_item(0, 0, 16'sh7FFF, 16'sh8000, 0, 0);
    send_item(0, 0, -16'sh0200, 16'sh0080, 1, 1);
    // Obstacle on the drone itself, then drone on the target.
    send_item(16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100, 1, 1);
    send_item(16'sh0400, 16'sh0300, 16'sh0401, 16'sh0300, 1, 1);
    send_item(16'sh0400, 16'sh0300, 0, 0, 0, 1);
    // Extreme coordinates with the largest and the smallest distances.
    send_item(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1, 1);
    send_item(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1, 0);
    send_item(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8001, 1, 1);
    send_item(16'sh0400, 16'sh0302, 16'sh0400, 16'sh0301, 1, 1);
    wait_drained();
    // Huge gains drive the accumulators into saturation.
    write_reg(REG_FORCE_GAIN, 32'h7FFF_FFFF);
    write_reg(REG_OWN_CHARGE, 32'h8000_0000);
    write_reg(REG_OBSTACLE_CHARGE, 32'h7FFF_FFFF);
    write_reg(REG_GOAL_CHARGE, 32'h8000_0000);
    write_reg(REG_TARGET_X, 32'h0000_8000);
    write_reg(REG_TARGET_Y, 32'h0000_7FFF);
    send_item(16'sh8001, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1, 0);
    send_item(16'sh8001, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1, 0);
    send_item(16'sh8000, 16'sh7FFE, 16'sh8000, 16'sh7FFF, 1, 1);
    send_item(16'sh0000, 16'sh0000, 16'sh0001, 16'sh0000, 1, 1);
    send_item(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1, 1);
    wait_drained();
    write_reg(REG_FORCE_GAIN, 32'h0000_0000);
    send_item(16'sh0010, 16'sh0020, 16'sh0030, 16'sh0040, 1, 1);
    wait_drained();
  endtask

  task automatic test_random(int items, int s_idle, int r_idle);
    int sent;
    int run_len;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    sent = 0;
    while (sent < items) begin
      randomize_regs();
      for (int n = 0; n < 50 && sent < items; ) begin
        run_len = $urandom_range(1, 6);
        dx = pick_coord(16'($signed(shadow_regs[REG_TARGET_X][CW-1:0])));
        dy = pick_coord(16'($signed(shadow_regs[REG_TARGET_Y][CW-1:0])));
        for (int i = 0; i < run_len; i++) begin
          // Occasionally the drone's x position moves within a run.
          if ($urandom_range(9) == 0) dx = $urandom();
          send_item(dx, dy, pick_coord(dx), pick_coord(dy), $urandom_range(3) != 0,
                    (i == run_len - 1) || ($urandom_range(15) == 0));
          sent++;
          n++;
        end
      end
      wait_drained();
    end
  endtask

  task automatic test_pause_until_drained();
    send_idle_pct = 0;
    recv_idle_pct = 50;
    for (int i = 0; i < 4; i++) send_item(16'sh0100, 0, 16'sh0200, 0, 1, 1);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_forces.size() != 0) @(posedge clk);
    for (int i = 0; i < 4; i++) send_item(0, 16'sh0100, 0, 16'sh0180, 1, 1);
    wait_drained();
  endtask

  initial begin
    failed = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 6; i++) shadow_regs[i] = '0;
    shadow_regs[REG_FORCE_GAIN] = FORCE_GAIN_RST;
    accum_x = 0;
    accum_y = 0;
    zero_dist_flag = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_drone_x <= '0;
    in_drone_y <= '0;
    in_obstacle_x <= '0;
    in_obstacle_y <= '0;
    in_obstacle_valid <= 1'b0;
    in_last <= 1'b0;
    out_ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);

    // Reset values first: gain 1.0 with zero charges gives zero force.
    send_item(16'sh0100, 16'sh0200, 16'sh0300, 16'sh0400, 1, 1);
    wait_drained();
    test_directed();
    test_pause_until_drained();
    test_random(250, 36, 84);
    test_random(250, 84, 36);
    test_random(250, 0, 0);
    wait_drained();

    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/pffa_pkg.sv
sv/potential_field_force_accumulator.sv
tb/testbench.sv
